>>> design/hbpt_pkg.sv
// Shared types, codes and constants of the presence table.
package hbpt_pkg;

   // operation codes of the kind field
   localparam logic [2:0] KIND_JOIN      = 3'd0;
   localparam logic [2:0] KIND_LEAVE     = 3'd1;
   localparam logic [2:0] KIND_HEARTBEAT = 3'd2;
   localparam logic [2:0] KIND_SET_STAT  = 3'd3;
   localparam logic [2:0] KIND_TICK      = 3'd4;

   // member status codes
   localparam logic [1:0] ST_OFFLINE = 2'd0;
   localparam logic [1:0] ST_ONLINE  = 2'd1;
   localparam logic [1:0] ST_IDLE    = 2'd2;
   localparam logic [1:0] ST_AWAY    = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_IDLE_AFTER = 2'd0;
   localparam logic [1:0] CSR_AWAY_AFTER = 2'd1;
   localparam logic [1:0] CSR_DROP_AFTER = 2'd2;

   localparam logic [31:0] IDLE_AFTER_RESET = 32'd30000;
   localparam logic [31:0] AWAY_AFTER_RESET = 32'd120000;
   localparam logic [31:0] DROP_AFTER_RESET = 32'd300000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] member_id;
      logic        host_flag;
      logic [1:0]  new_status;
      logic [31:0] time_now;
   } req_type;

   typedef struct packed {
      logic       refused;
      logic [4:0] slot_index;
      logic [5:0] present_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [1:0]  status;
      logic        host;
      logic [31:0] last_seen;
   } entry_type;

   typedef struct packed {
      logic [31:0] idle_after;
      logic [31:0] away_after;
      logic [31:0] drop_after;
   } thresholds_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
      logic [1:0] old_status;
   } demote_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_SHIFT,
      S_TICK,
      S_FIN
   } state_type;

   function automatic logic is_present(input logic [1:0] st);
      return (st == ST_ONLINE) || (st == ST_IDLE);
   endfunction

endpackage

>>> design/heartbeat_presence_table_unit.sv
// Presence table top level: entry memory, walk sequencer and result register.
//
// The table lives in one entry memory with a registered read port and one write
// port; a sequencer walks it one entry per cycle. The result word of a join,
// heartbeat, set-status or tick follows the lookup or read walk, plus the update or
// the silence and demote stages in flight. A leave lookup stops at the hit and the
// compaction of the later entries starts there. A non-tick item with a zero id, or an
// item of an unused kind, skips the walk and is refused. The next word can be taken in
// the same cycle as the result appears. The block takes the next word as soon as the
// sequencer is back in idle, even while the previous result still waits on rsp_stall.
// The memory needs no clearing after reset: only occupied entries are read.
module heartbeat_presence_table_unit
   import hbpt_pkg::*;
#(
   parameter int ROSTER_SLOTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IW = (ROSTER_SLOTS > 1) ? $clog2(ROSTER_SLOTS) : 1;
   localparam int CW = $clog2(ROSTER_SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(ROSTER_SLOTS);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   entry_type mem [ROSTER_SLOTS];

   state_type      state_ff, state_in;
   req_type        item_ff, item_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  present_ff, present_in;
   logic [31:0]    cur_time_ff, cur_time_in;
   logic [IW-1:0]  slot_ff, slot_in;
   logic           found_ff, found_in;
   entry_type      hit_ff, hit_in;
   logic           res_refused_ff, res_refused_in;
   logic [IW-1:0]  res_slot_ff, res_slot_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   thresholds_type thr_ff, thr_in;

   logic           rd_valid_ff;
   logic [IW-1:0]  rd_tag_ff;
   entry_type      rd_data_ff;
   logic [IW-1:0]  tag2_ff;

   logic           rd_en;
   logic [IW-1:0]  rd_addr;
   logic           wr_en;
   logic [IW-1:0]  wr_addr;
   entry_type      wr_data;

   demote_type     dem;
   entry_type      upd;
   logic           accept;
   logic [IW+4:0]  slot_wide;
   logic [CW+5:0]  present_wide;

   hbpt_demote u_demote (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff && state_ff == S_TICK),
      .in_entry (rd_data_ff),
      .now      (cur_time_ff),
      .thr      (thr_ff),
      .dem_out  (dem)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign slot_wide    = {5'd0, res_slot_ff};
   assign present_wide = {6'd0, present_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         cur_time_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         thr_ff       <= '{IDLE_AFTER_RESET, AWAY_AFTER_RESET, DROP_AFTER_RESET};
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         cur_time_ff  <= cur_time_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_en;
         thr_ff       <= thr_in;
      end
      item_ff        <= item_in;
      ptr_ff         <= ptr_in;
      slot_ff        <= slot_in;
      found_ff       <= found_in;
      hit_ff         <= hit_in;
      res_refused_ff <= res_refused_in;
      res_slot_ff    <= res_slot_in;
      rsp_data_ff    <= rsp_data_in;
      rd_tag_ff      <= rd_addr;
      tag2_ff        <= rd_tag_ff;
   end

   always_comb begin
      thr_in = thr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IDLE_AFTER: thr_in.idle_after = csr_data;
            CSR_AWAY_AFTER: thr_in.away_after = csr_data;
            CSR_DROP_AFTER: thr_in.drop_after = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      ptr_in         = ptr_ff;
      count_in       = count_ff;
      present_in     = present_ff;
      cur_time_in    = cur_time_ff;
      slot_in        = slot_ff;
      found_in       = found_ff;
      hit_in         = hit_ff;
      res_refused_in = res_refused_ff;
      res_slot_in    = res_slot_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rd_en          = 1'b0;
      rd_addr        = ptr_ff[IW-1:0];
      wr_en          = 1'b0;
      wr_addr        = slot_ff;
      wr_data        = hit_ff;
      upd            = hit_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in        = req_data;
               ptr_in         = '0;
               found_in       = 1'b0;
               res_refused_in = 1'b0;
               res_slot_in    = '0;
               if (req_data.kind == KIND_TICK) begin
                  cur_time_in = req_data.time_now;
                  state_in    = S_TICK;
               end else if (req_data.kind > KIND_TICK || req_data.member_id == 32'd0) begin
                  res_refused_in = 1'b1;
                  state_in       = S_FIN;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (rd_valid_ff && rd_data_ff.id == item_ff.member_id) begin
               found_in = 1'b1;
               slot_in  = rd_tag_ff;
               hit_in   = rd_data_ff;
               state_in = S_APPLY;
            end else if (ptr_ff < count_ff) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + ONE_C;
            end else if (!rd_valid_ff) begin
               state_in = S_APPLY;
            end
         end

         S_APPLY: begin
            state_in = S_FIN;
            case (item_ff.kind)
               KIND_JOIN: begin
                  if (found_ff) begin
                     upd.host      = item_ff.host_flag;
                     upd.status    = ST_ONLINE;
                     upd.last_seen = cur_time_ff;
                     wr_en         = 1'b1;
                     wr_data       = upd;
                     present_in    = present_ff + ONE_C
                                     - CW'(is_present(hit_ff.status));
                     res_slot_in   = slot_ff;
                  end else if (count_ff == SLOTS_C) begin
                     res_refused_in = 1'b1;
                  end else begin
                     upd.id        = item_ff.member_id;
                     upd.host      = item_ff.host_flag;
                     upd.status    = ST_ONLINE;
                     upd.last_seen = cur_time_ff;
                     wr_en         = 1'b1;
                     wr_addr       = count_ff[IW-1:0];
                     wr_data       = upd;
                     count_in      = count_ff + ONE_C;
                     present_in    = present_ff + ONE_C;
                     res_slot_in   = count_ff[IW-1:0];
                  end
               end
               KIND_LEAVE: begin
                  if (found_ff) begin
                     present_in = present_ff - CW'(is_present(hit_ff.status));
                     ptr_in     = CW'(slot_ff) + ONE_C;
                     state_in   = S_SHIFT;
                  end else begin
                     res_refused_in = 1'b1;
                  end
               end
               KIND_HEARTBEAT: begin
                  if (found_ff) begin
                     upd.status    = ST_ONLINE;
                     upd.last_seen = cur_time_ff;
                     wr_en         = 1'b1;
                     wr_data       = upd;
                     present_in    = present_ff + ONE_C
                                     - CW'(is_present(hit_ff.status));
                  end else begin
                     res_refused_in = 1'b1;
                  end
               end
               KIND_SET_STAT: begin
                  if (found_ff) begin
                     upd.status = item_ff.new_status;
                     if (item_ff.new_status != ST_OFFLINE) begin
                        upd.last_seen = cur_time_ff;
                     end
                     wr_en      = 1'b1;
                     wr_data    = upd;
                     present_in = present_ff + CW'(is_present(item_ff.new_status))
                                  - CW'(is_present(hit_ff.status));
                  end else begin
                     res_refused_in = 1'b1;
                  end
               end
               default: begin
                  res_refused_in = 1'b1;
               end
            endcase
         end

         S_SHIFT: begin
            // each word read at slot k lands one slot lower
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_tag_ff - IW'(1);
               wr_data = rd_data_ff;
            end
            if (ptr_ff < count_ff) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + ONE_C;
            end else if (!rd_valid_ff) begin
               count_in = count_ff - ONE_C;
               state_in = S_FIN;
            end
         end

         S_TICK: begin
            if (dem.valid) begin
               wr_en      = 1'b1;
               wr_addr    = tag2_ff;
               wr_data    = dem.entry;
               present_in = present_ff + CW'(is_present(dem.entry.status))
                            - CW'(is_present(dem.old_status));
            end
            if (ptr_ff < count_ff) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + ONE_C;
            end else if (!rd_valid_ff && !dem.valid) begin
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.refused       = res_refused_ff;
               rsp_data_in.slot_index    = res_refused_ff ? 5'd0 : slot_wide[4:0];
               rsp_data_in.present_count = present_wide[5:0];
               state_in                  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> design/hbpt_demote.sv
// Tick demotion stage: silence of one entry and its new status.
module hbpt_demote
   import hbpt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  entry_type      in_entry,
   input  logic [31:0]    now,
   input  thresholds_type thr,
   output demote_type     dem_out
);

   logic        valid_ff;
   entry_type   entry_ff;
   logic [31:0] silence_ff;
   logic [31:0] silence_in;
   logic [1:0]  status_new;

   // silence clamps at zero when last_seen lies ahead of now
   assign silence_in = (now >= in_entry.last_seen) ? (now - in_entry.last_seen) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      entry_ff   <= in_entry;
      silence_ff <= silence_in;
   end

   always_comb begin
      status_new = entry_ff.status;
      if (entry_ff.status != ST_OFFLINE) begin
         if (silence_ff >= thr.drop_after) begin
            status_new = ST_OFFLINE;
         end else if (silence_ff >= thr.away_after) begin
            status_new = ST_AWAY;
         end else if (silence_ff >= thr.idle_after && entry_ff.status == ST_ONLINE) begin
            status_new = ST_IDLE;
         end
      end
      dem_out.valid        = valid_ff;
      dem_out.entry        = entry_ff;
      dem_out.entry.status = status_new;
      dem_out.old_status   = entry_ff.status;
   end

endmodule
